### sv/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Result type and code constants shared by the decoder logic.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam int UNIT_W = 31;

    localparam logic [UNIT_W-1:0] SURR_HIGH_BASE = 31'h0000_D800;
    localparam logic [UNIT_W-1:0] SURR_LOW_BASE  = 31'h0000_DC00;
    localparam logic [UNIT_W-1:0] PLANE1_BASE    = 31'h0001_0000;
    localparam logic [UNIT_W-1:0] UNICODE_MAX    = 31'h0010_FFFF;
    localparam logic [9:0]        SURR_MASK      = 10'h3FF;
    localparam logic [7:0]        CONT_MASK      = 8'hC0;
    localparam logic [7:0]        CONT_TAG       = 8'h80;
    localparam logic [5:0]        CONT_BITS      = 6'h3F;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              is_error;
        logic              last_of_run;
        logic              end_of_string;
    } t_result;

endpackage

### sv/utf8_to_utf16_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder
// Decodes a UTF-8 byte stream (1 to 6 byte forms) into code points or
// UTF-16 units with surrogate pairs, and flags malformed strings.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transaction
//  s_axis    in         one UTF-8 byte, tlast marks the final byte of a string
//  m_axis    out        one code point or UTF-16 unit, tlast on last per byte
//  cfg       in         wide_units mode bit
//
// An accepted byte is registered, decoded from that register and its
// results are written to a two-entry output buffer, so one byte per cycle is
// sustained while the output keeps up.
// The high surrogate goes out first while the low one waits in the second
// entry; a byte stalls only when its results do not fit in the buffer.
// Reset is synchronous and clears the decode state and the mode bit.
// A stalled output holds the input register, which then deasserts tready.
module utf8_to_utf16_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,    // wide_units
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] byte_in
    input  logic        s_axis_tlast,  // string_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [30:0] unit, [31] zero
    output logic        m_axis_tlast,  // last_of_run
    output logic [1:0]  m_axis_tuser   // [0] is_error, [1] end_of_string
);

    logic                r_wide;
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_end;
    logic [30:0]         r_acc;
    logic [2:0]          r_pend;
    logic                r_disc;
    logic                r_out_valid;
    logic                r_low_valid;
    u8u16_pkg::t_result  r_out;
    u8u16_pkg::t_result  r_low;

    logic [30:0]         n_acc;
    logic [2:0]          n_pend;
    logic                n_disc;
    logic                n_out_valid;
    logic                n_low_valid;
    u8u16_pkg::t_result  n_out;
    u8u16_pkg::t_result  n_low;
    logic [1:0]          d_nres;
    u8u16_pkg::t_result  d_res0;
    u8u16_pkg::t_result  d_res1;
    logic                pop;
    logic                room1;
    logic                room2;
    logic                fire;

    assign o_cfg_ready   = 1'b1;
    assign pop           = r_out_valid && m_axis_tready;
    assign room2         = !r_out_valid || (pop && !r_low_valid);
    assign room1         = !r_low_valid || pop;
    assign fire          = r_in_valid && ((d_nres == 2'd0)
                                       || (d_nres == 2'd1 && room1)
                                       || (d_nres == 2'd2 && room2));
    assign s_axis_tready = !r_in_valid || fire;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.unit};
    assign m_axis_tlast  = r_out.last_of_run;
    assign m_axis_tuser  = {r_out.end_of_string, r_out.is_error};

    always_comb begin
        logic [30:0] acc_new;
        logic [2:0]  pend_new;
        logic        err;
        logic [19:0] off;
        acc_new  = r_acc;
        pend_new = r_pend;
        err      = 1'b0;
        off      = '0;
        n_acc    = r_acc;
        n_pend   = r_pend;
        n_disc   = r_disc;
        d_nres   = 2'd0;
        d_res0   = '{unit: '0, is_error: 1'b0, last_of_run: 1'b1,
                     end_of_string: r_in_end};
        d_res1   = d_res0;

        if (r_disc) begin
            n_disc = !r_in_end;
        end else begin
            if (r_pend == 3'd0) begin
                case (r_in_byte) inside
                    [8'h00:8'h7F]: begin
                        acc_new = {23'd0, r_in_byte};
                        pend_new = 3'd0;
                    end
                    [8'hC0:8'hDF]: begin
                        acc_new = {26'd0, r_in_byte[4:0]};
                        pend_new = 3'd1;
                    end
                    [8'hE0:8'hEF]: begin
                        acc_new = {27'd0, r_in_byte[3:0]};
                        pend_new = 3'd2;
                    end
                    [8'hF0:8'hF7]: begin
                        acc_new = {28'd0, r_in_byte[2:0]};
                        pend_new = 3'd3;
                    end
                    [8'hF8:8'hFB]: begin
                        acc_new = {29'd0, r_in_byte[1:0]};
                        pend_new = 3'd4;
                    end
                    [8'hFC:8'hFD]: begin
                        acc_new = {30'd0, r_in_byte[0]};
                        pend_new = 3'd5;
                    end
                    default: begin
                        err = 1'b1;
                    end
                endcase
            end else begin
                if ((r_in_byte & u8u16_pkg::CONT_MASK) != u8u16_pkg::CONT_TAG) begin
                    err = 1'b1;
                end else begin
                    acc_new  = {r_acc[24:0], r_in_byte[5:0] & u8u16_pkg::CONT_BITS};
                    pend_new = r_pend - 3'd1;
                end
            end

            if (!err) begin
                if (pend_new != 3'd0) begin
                    if (r_in_end) begin
                        err = 1'b1;
                    end else begin
                        n_acc  = acc_new;
                        n_pend = pend_new;
                    end
                end else begin
                    n_acc  = '0;
                    n_pend = 3'd0;
                    if (r_wide || acc_new < u8u16_pkg::PLANE1_BASE) begin
                        d_nres      = 2'd1;
                        d_res0.unit = acc_new;
                    end else if (acc_new > u8u16_pkg::UNICODE_MAX) begin
                        err = 1'b1;
                    end else begin
                        off                = acc_new[19:0] - u8u16_pkg::PLANE1_BASE[19:0];
                        d_nres             = 2'd2;
                        d_res0.unit        = u8u16_pkg::SURR_HIGH_BASE | {21'd0, off[19:10]};
                        d_res0.last_of_run = 1'b0;
                        d_res1.unit        = u8u16_pkg::SURR_LOW_BASE
                                           | {21'd0, off[9:0] & u8u16_pkg::SURR_MASK};
                    end
                end
            end

            if (err) begin
                n_acc           = '0;
                n_pend          = 3'd0;
                n_disc          = !r_in_end;
                d_nres          = 2'd1;
                d_res0.unit     = '0;
                d_res0.is_error = 1'b1;
            end
        end
    end

    always_comb begin
        n_out       = r_out;
        n_low       = r_low;
        n_out_valid = r_out_valid;
        n_low_valid = r_low_valid;
        if (pop) begin
            n_out       = r_low;
            n_out_valid = r_low_valid;
            n_low_valid = 1'b0;
        end
        if (fire) begin
            if (d_nres == 2'd2) begin
                n_out       = d_res0;
                n_out_valid = 1'b1;
                n_low       = d_res1;
                n_low_valid = 1'b1;
            end else if (d_nres == 2'd1) begin
                if (n_out_valid) begin
                    n_low       = d_res0;
                    n_low_valid = 1'b1;
                end else begin
                    n_out       = d_res0;
                    n_out_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide      <= 1'b0;
            r_in_valid  <= 1'b0;
            r_acc       <= '0;
            r_pend      <= 3'd0;
            r_disc      <= 1'b0;
            r_out_valid <= 1'b0;
            r_low_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_wide <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (fire) begin
                r_acc  <= n_acc;
                r_pend <= n_pend;
                r_disc <= n_disc;
            end
            r_out_valid <= n_out_valid;
            r_low_valid <= n_low_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_end  <= s_axis_tlast;
        end
        r_out <= n_out;
        r_low <= n_low;
    end

    a_low_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low_valid |-> r_out_valid)
        else $error("Second output entry valid while the first one is empty.");

    a_high_has_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last_of_run) |-> r_low_valid)
        else $error("High surrogate in the output register without its low unit.");

    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != 3'd6) && (r_pend != 3'd7))
        else $error("Pending continuation count out of range.");

    a_disc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disc |-> (r_pend == 3'd0 && r_acc == '0))
        else $error("Decode state not cleared while a string is dropped.");

endmodule
